/* src/assert_macros.svh */
// Assertion macros for the RTL of the node search block, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define BRS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Implication checked in the same cycle outside reset.
`define BRS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/brs_pkg.sv */
// Package with the operation codes, defaults and token control type of the node search.
package brs_pkg;

  localparam int MAX_KEYS_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int FIELD_W       = 32;
  localparam int OP_W          = 2;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd1;
  localparam logic [OP_W-1:0] OP_POINT = 2'd2;
  localparam logic [OP_W-1:0] OP_EXACT = 2'd3;

  // Control part of the item that travels along the chain.
  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
    logic            done;
    logic            found;
  } ctl_t;

  function automatic logic is_search(input logic [OP_W-1:0] op);
    return (op == OP_POINT) || (op == OP_EXACT);
  endfunction

endpackage

/* src/btree_node_range_search.sv */
// Top level of the B-tree node key range search.
//
// This block holds one B-tree node of up to MAX_KEYS key ranges, one range in each cell of a
// chain, together with a count of valid keys. Every item, write or search, enters the first
// cell and moves one cell on in each cycle that the chain advances, so writes and searches
// act in the order they were accepted. A write stores its bounds as it passes the cell named
// by entry_index; a write to a slot outside the node is dropped. A count item takes effect at
// once on entry and is saturated to MAX_KEYS. A search closes at the first cell below the
// count whose low bound exceeds the query (found clear) or whose range holds or equals the
// query (found set), and otherwise reports the count. A new item is accepted in every cycle
// in which no result waits at the output. A search has passed all MAX_KEYS cell registers
// when its result is presented; the last cell's register drives the output directly.
// The chain moves as a whole: while a result waits at the output, nothing is accepted.
// Keys that were never written read as unknown values; searches must not reach them.
`include "assert_macros.svh"

module btree_node_range_search #(
  parameter int MAX_KEYS  = brs_pkg::MAX_KEYS_DEF,
  parameter int KEY_WIDTH = brs_pkg::KEY_WIDTH_DEF,
  localparam int IDX_W    = $clog2(MAX_KEYS),
  localparam int CNT_W    = $clog2(MAX_KEYS + 1),
  localparam int IN_BITS  = brs_pkg::OP_W + IDX_W + CNT_W + 2 * brs_pkg::FIELD_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = CNT_W + 1,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Fields from bit 0 up: op, entry_index, new_count, range_low, range_high, zero padding.
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // Fields from bit 0 up: match_index, found, zero padding.
  output logic [OUT_W-1:0] m_axis_tdata_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i
);

  localparam int EXT_W = (KEY_WIDTH > brs_pkg::FIELD_W) ? KEY_WIDTH : brs_pkg::FIELD_W;
  localparam int LO_LSB = brs_pkg::OP_W + IDX_W + CNT_W;
  localparam int HI_LSB = LO_LSB + brs_pkg::FIELD_W;

  // Unpacked input fields.
  logic [brs_pkg::OP_W-1:0] in_op;
  logic [IDX_W-1:0]         in_idx;
  logic [CNT_W-1:0]         in_cnt;
  logic [EXT_W-1:0]         in_lo_ext, in_hi_ext;

  logic [CNT_W-1:0] count_d, count_q;
  logic             adv;
  logic             accept;

  // Chain taps: element 0 is the item entering, element MAX_KEYS the output register.
  brs_pkg::ctl_t        ctl [MAX_KEYS+1];
  logic [IDX_W-1:0]     idx [MAX_KEYS+1];
  logic [CNT_W-1:0]     cnt [MAX_KEYS+1];
  logic [CNT_W-1:0]     pos [MAX_KEYS+1];
  logic [KEY_WIDTH-1:0] qlo [MAX_KEYS+1];
  logic [KEY_WIDTH-1:0] qhi [MAX_KEYS+1];

  assign in_op     = s_axis_tdata_i[0 +: brs_pkg::OP_W];
  assign in_idx    = s_axis_tdata_i[brs_pkg::OP_W +: IDX_W];
  assign in_cnt    = s_axis_tdata_i[brs_pkg::OP_W + IDX_W +: CNT_W];
  assign in_lo_ext = EXT_W'(s_axis_tdata_i[LO_LSB +: brs_pkg::FIELD_W]);
  assign in_hi_ext = EXT_W'(s_axis_tdata_i[HI_LSB +: brs_pkg::FIELD_W]);

  // The whole chain advances unless a finished result is held at the output.
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i && adv;

  // The key count lives at the chain entry; each search picks up the count in force.
  always_comb begin
    count_d = count_q;
    if (accept && (in_op == brs_pkg::OP_COUNT)) begin
      count_d = (in_cnt > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : in_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign ctl[0].valid = s_axis_tvalid_i;
  assign ctl[0].op    = in_op;
  assign ctl[0].done  = 1'b0;
  assign ctl[0].found = 1'b0;
  assign idx[0]       = in_idx;
  assign cnt[0]       = count_q;
  assign pos[0]       = count_q;
  assign qlo[0]       = in_lo_ext[KEY_WIDTH-1:0];
  assign qhi[0]       = in_hi_ext[KEY_WIDTH-1:0];

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    brs_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .INDEX     (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctl_i  (ctl[g]),
      .idx_i  (idx[g]),
      .cnt_i  (cnt[g]),
      .pos_i  (pos[g]),
      .qlo_i  (qlo[g]),
      .qhi_i  (qhi[g]),
      .ctl_o  (ctl[g+1]),
      .idx_o  (idx[g+1]),
      .cnt_o  (cnt[g+1]),
      .pos_o  (pos[g+1]),
      .qlo_o  (qlo[g+1]),
      .qhi_o  (qhi[g+1])
    );
  end

  // Writes and count items leave the end of the chain silently; only searches give a result.
  assign m_axis_tvalid_o = ctl[MAX_KEYS].valid && brs_pkg::is_search(ctl[MAX_KEYS].op);
  assign m_axis_tdata_o  = OUT_W'({ctl[MAX_KEYS].found, pos[MAX_KEYS]});

  // The last cell's index and bounds have no further consumer; they only feed the checks below.
  `BRS_ASSERT(a_ready_when_empty, m_axis_tvalid_o || s_axis_tready_o,
              "input stalled while no result is pending")
  `BRS_ASSERT(a_count_range, count_q <= CNT_W'(MAX_KEYS), "key count beyond node size")
  `BRS_ASSERT_IMP(a_found_index, m_axis_tvalid_o && ctl[MAX_KEYS].found,
                  (pos[MAX_KEYS] < cnt[MAX_KEYS]) && ctl[MAX_KEYS].done,
                  "found result outside the valid keys")
  `BRS_ASSERT_IMP(a_pos_le_count, m_axis_tvalid_o, pos[MAX_KEYS] <= cnt[MAX_KEYS],
                  "result index beyond the key count")
  `BRS_ASSERT_IMP(a_write_tail, ctl[MAX_KEYS].valid && (ctl[MAX_KEYS].op == brs_pkg::OP_WRITE),
                  !ctl[MAX_KEYS].done && (idx[MAX_KEYS] == idx[MAX_KEYS]) &&
                  (qlo[MAX_KEYS] == qlo[MAX_KEYS]) && (qhi[MAX_KEYS] == qhi[MAX_KEYS]),
                  "write item closed by a cell")

endmodule

/* src/brs_cell.sv */
// One cell of the chain: holds one key range and tests the passing item against it.
module brs_cell #(
  parameter int KEY_WIDTH = brs_pkg::KEY_WIDTH_DEF,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5,
  parameter int INDEX     = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  brs_pkg::ctl_t        ctl_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic [CNT_W-1:0]     cnt_i,
  input  logic [CNT_W-1:0]     pos_i,
  input  logic [KEY_WIDTH-1:0] qlo_i,
  input  logic [KEY_WIDTH-1:0] qhi_i,
  output brs_pkg::ctl_t        ctl_o,
  output logic [IDX_W-1:0]     idx_o,
  output logic [CNT_W-1:0]     cnt_o,
  output logic [CNT_W-1:0]     pos_o,
  output logic [KEY_WIDTH-1:0] qlo_o,
  output logic [KEY_WIDTH-1:0] qhi_o
);

  logic [KEY_WIDTH-1:0] klo_q, khi_q;
  brs_pkg::ctl_t        ctl_d, ctl_q;
  logic [CNT_W-1:0]     pos_d, pos_q;
  logic [IDX_W-1:0]     idx_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [KEY_WIDTH-1:0] qlo_q, qhi_q;
  logic                 key_wr;
  logic                 live;
  logic                 below;
  logic                 match;

  assign key_wr = en_i && ctl_i.valid && (ctl_i.op == brs_pkg::OP_WRITE) &&
                  (idx_i == IDX_W'(INDEX));

  // The key takes part only while the search is still open and this slot is below the count.
  assign live  = ctl_i.valid && brs_pkg::is_search(ctl_i.op) && !ctl_i.done &&
                 (CNT_W'(INDEX) < cnt_i);
  assign below = qlo_i < klo_q;
  assign match = (ctl_i.op == brs_pkg::OP_POINT) ? (qlo_i <= khi_q)
                                                 : ((qlo_i == klo_q) && (qhi_i == khi_q));

  always_comb begin
    ctl_d = ctl_i;
    pos_d = pos_i;
    if (live && (below || match)) begin
      ctl_d.done  = 1'b1;
      ctl_d.found = !below;
      pos_d       = CNT_W'(INDEX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_wr) begin
      klo_q <= qlo_i;
      khi_q <= qhi_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q <= pos_d;
      idx_q <= idx_i;
      cnt_q <= cnt_i;
      qlo_q <= qlo_i;
      qhi_q <= qhi_i;
    end
  end

  assign ctl_o = ctl_q;
  assign idx_o = idx_q;
  assign cnt_o = cnt_q;
  assign pos_o = pos_q;
  assign qlo_o = qlo_q;
  assign qhi_o = qhi_q;

endmodule

/* bench/tb_btree_node_range_search.sv */
// Self-checking testbench for the B-tree node key range search block.
`timescale 1ns / 100ps

module tb_btree_node_range_search;

  localparam int MAX_KEYS    = brs_pkg::MAX_KEYS_DEF;
  localparam int KEY_W       = brs_pkg::KEY_WIDTH_DEF;
  localparam int OP_W        = brs_pkg::OP_W;
  localparam int FIELD_W     = brs_pkg::FIELD_W;
  localparam int IDX_W       = $clog2(MAX_KEYS);
  localparam int CNT_W       = $clog2(MAX_KEYS + 1);
  localparam int IN_BITS     = OP_W + IDX_W + CNT_W + 2 * FIELD_W;
  localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W       = ((CNT_W + 1 + 7) / 8) * 8;
  localparam int ITEM_TARGET = 1150;
  localparam int CYCLE_LIMIT = 400000;

  // One input item, op in the lowest bits as on the stream.
  typedef struct packed {
    logic [FIELD_W-1:0] range_high;
    logic [FIELD_W-1:0] range_low;
    logic [CNT_W-1:0]   new_count;
    logic [IDX_W-1:0]   entry_index;
    logic [OP_W-1:0]    op;
  } node_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] match_index;
    logic             found;
  } search_hit_t;

  // Shadow of the node plus the queue of search results still to come.
  class key_search_board;
    logic [KEY_W-1:0] low_bound  [MAX_KEYS];
    logic [KEY_W-1:0] high_bound [MAX_KEYS];
    logic [CNT_W-1:0] key_count;
    search_hit_t      expected_hits[$];
    int unsigned      failures;

    function new();
      key_count = '0;
      failures  = 0;
    endfunction

    // Scan the valid keys in slot order, as the node is searched.
    function search_hit_t locate_key(node_item_t it);
      search_hit_t hit;
      logic        hold;
      hit.found       = 1'b0;
      hit.match_index = key_count;
      for (int i = 0; i < key_count; i++) begin
        if (it.range_low[KEY_W-1:0] < low_bound[i]) begin
          hit.match_index = CNT_W'(i);
          return hit;
        end
        if (it.op == brs_pkg::OP_POINT) begin
          hold = (it.range_low[KEY_W-1:0] <= high_bound[i]);
        end else begin
          hold = (it.range_low[KEY_W-1:0] == low_bound[i]) &&
                 (it.range_high[KEY_W-1:0] == high_bound[i]);
        end
        if (hold) begin
          hit.found       = 1'b1;
          hit.match_index = CNT_W'(i);
          return hit;
        end
      end
      return hit;
    endfunction

    function void note_item(node_item_t it);
      case (it.op)
        brs_pkg::OP_WRITE: begin
          if (it.entry_index < MAX_KEYS) begin
            low_bound[it.entry_index]  = it.range_low[KEY_W-1:0];
            high_bound[it.entry_index] = it.range_high[KEY_W-1:0];
          end
        end
        brs_pkg::OP_COUNT: begin
          key_count = (it.new_count > MAX_KEYS) ? CNT_W'(MAX_KEYS) : it.new_count;
        end
        default: begin
          expected_hits.push_back(locate_key(it));
        end
      endcase
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      search_hit_t      want;
      logic [CNT_W-1:0] got_index;
      logic             got_found;
      got_index = data[CNT_W-1:0];
      got_found = data[CNT_W];
      if (expected_hits.size() == 0) begin
        $error("unexpected result: match_index %0d found %0d", got_index, got_found);
        failures++;
        return;
      end
      want = expected_hits.pop_front();
      if (got_index !== want.match_index) begin
        $error("match_index: expected %0d, actual %0d", want.match_index, got_index);
        failures++;
      end
      if (got_found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got_found);
        failures++;
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic [IN_W-1:0]  s_axis_tdata_i;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;

  key_search_board  board;
  int unsigned      cycle_count = 0;
  int unsigned      items_sent  = 0;
  int unsigned      burst_left  = 0;
  int unsigned      stall_mode  = 0;
  int unsigned      stall_left  = 0;

  // Bounds as last written, used only to aim queries near the stored keys.
  logic [31:0]      node_lo [MAX_KEYS];
  logic [31:0]      node_hi [MAX_KEYS];

  btree_node_range_search #(
    .MAX_KEYS (MAX_KEYS),
    .KEY_WIDTH(KEY_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: check every accepted result and stall in modes of random length, from
  // always ready through sparse acceptance to a fixed duty cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_result(m_axis_tdata_o);
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready_i <= ((cycle_count % 7) < 3);
    endcase
  end

  // Offer one item, hold it until taken, then count down the burst and idle between bursts.
  task automatic send_item(input node_item_t it);
    int unsigned gap;
    s_axis_tdata_i  <= IN_W'(it);
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_item(it);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= IN_W'({$urandom, $urandom, $urandom});
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_key(input int slot, input logic [31:0] lo, input logic [31:0] hi);
    node_item_t it;
    it.op          = brs_pkg::OP_WRITE;
    it.entry_index = IDX_W'(slot);
    it.new_count   = CNT_W'($urandom);
    it.range_low   = lo;
    it.range_high  = hi;
    node_lo[slot]  = lo;
    node_hi[slot]  = hi;
    send_item(it);
  endtask

  task automatic set_count(input int unsigned cnt);
    node_item_t it;
    it.op          = brs_pkg::OP_COUNT;
    it.entry_index = IDX_W'($urandom);
    it.new_count   = CNT_W'(cnt);
    it.range_low   = $urandom;
    it.range_high  = $urandom;
    send_item(it);
  endtask

  task automatic search(input logic [OP_W-1:0] op, input logic [31:0] lo,
                        input logic [31:0] hi);
    node_item_t it;
    it.op          = op;
    it.entry_index = IDX_W'($urandom);
    it.new_count   = CNT_W'($urandom);
    it.range_low   = lo;
    it.range_high  = hi;
    send_item(it);
  endtask

  // Stop offering items until every search result has come back.
  task automatic wait_drained();
    if (s_axis_tvalid_i) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Fill the whole node with keys in ascending order of low. The spacing scale decides
  // whether neighbouring keys touch, overlap or leave wide gaps; now and then a key is
  // fully random, which breaks the order on purpose.
  task automatic load_node();
    longint unsigned cursor;
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     scale;
    case ($urandom_range(0, 3))
      0: scale = 1;
      1: scale = 16;
      2: scale = 1 << 20;
      default: scale = 1 << 27;
    endcase
    cursor = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1000);
    for (int s = 0; s < MAX_KEYS; s++) begin
      lo = cursor + $urandom_range(0, scale);
      hi = lo + $urandom_range(0, scale);
      if (s == MAX_KEYS - 1 && $urandom_range(0, 3) == 0) hi = 64'hFFFF_FFFF;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      cursor = ($urandom_range(0, 4) == 0) ? hi : hi + 1;
      if ($urandom_range(0, 9) == 0) begin
        write_key(s, $urandom, $urandom);
      end else begin
        write_key(s, lo[31:0], hi[31:0]);
      end
    end
  endtask

  task automatic random_count();
    case ($urandom_range(0, 7))
      0: set_count(0);
      1: set_count($urandom_range(MAX_KEYS, 31));
      default: set_count($urandom_range(1, MAX_KEYS));
    endcase
  endtask

  // A search aimed at the edges of one stored key, or now and then anywhere at all.
  task automatic aimed_search();
    int unsigned      j;
    logic [OP_W-1:0]  op;
    logic [31:0]      lo;
    logic [31:0]      hi;
    j  = $urandom_range(0, MAX_KEYS - 1);
    op = $urandom_range(0, 1) ? brs_pkg::OP_POINT : brs_pkg::OP_EXACT;
    case ($urandom_range(0, 6))
      0: lo = node_lo[j] - 1;
      1: lo = node_lo[j];
      2: lo = node_hi[j];
      3: lo = node_hi[j] + 1;
      4: lo = node_lo[j] + ((node_hi[j] - node_lo[j]) >> 1);
      5: lo = $urandom;
      default: lo = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
    case ($urandom_range(0, 5))
      0: hi = node_hi[j] + 1;
      1: hi = node_hi[j] - 1;
      2: hi = $urandom;
      default: hi = node_hi[j];
    endcase
    search(op, lo, hi);
  endtask

  initial begin
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    rst_ni          <= 1'b0;
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The node is empty straight after reset.
    search(brs_pkg::OP_POINT, 32'h0, 32'h0);
    search(brs_pkg::OP_EXACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // A node with a degenerate first key, gaps between keys and a last key up to the top.
    write_key(0, 32'h0, 32'h0);
    for (int s = 1; s < MAX_KEYS - 1; s++) begin
      write_key(s, (s << 28) | 32'h100, (s << 28) | 32'h0FFF_FF00);
    end
    write_key(MAX_KEYS - 1, 32'hF000_0100, 32'hFFFF_FFFF);
    // A count beyond the node is held at the node size.
    set_count(31);
    search(brs_pkg::OP_POINT, 32'hFFFF_FFFF, 32'h0);
    search(brs_pkg::OP_POINT, 32'h0, 32'hFFFF_FFFF);
    search(brs_pkg::OP_POINT, 32'h50, 32'h0);
    search(brs_pkg::OP_POINT, 32'h1FFF_FF01, 32'h0);
    search(brs_pkg::OP_EXACT, 32'h1000_0100, 32'h1FFF_FF00);
    search(brs_pkg::OP_EXACT, 32'h1000_0100, 32'h1FFF_FF01);
    set_count(MAX_KEYS);
    search(brs_pkg::OP_POINT, 32'hF000_0100, 32'h0);
    // With three keys a query above them all runs out at the count.
    set_count(3);
    search(brs_pkg::OP_POINT, 32'h8000_0000, 32'h0);
    set_count(0);
    search(brs_pkg::OP_POINT, 32'h1234_5678, 32'h0);
    wait_drained();

    // Random part: mostly well-formed nodes searched near their keys, with stray
    // rewrites and count changes in between.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) load_node();
      random_count();
      repeat ($urandom_range(8, 40)) begin
        case ($urandom_range(0, 19))
          0: write_key($urandom_range(0, MAX_KEYS - 1), $urandom, $urandom);
          1: random_count();
          default: aimed_search();
        endcase
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (MAX_KEYS + 8) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
